/* hw/rtl/assert_macros.svh */
// assertion macros for the bit engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/i2cm_pkg.sv */
// types and constants of the i2c master bit engine
package i2cm_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned STEP_W   = 3;
    localparam int unsigned BITCNT_W = 4;
    localparam int unsigned TIMER_W  = 8;

    localparam logic [BITCNT_W-1:0] RECOVER_PULSES    = 4'd9;
    localparam logic [BITCNT_W-1:0] BYTE_BITS         = 4'd8;
    localparam logic [TIMER_W-1:0]  PHASE_TICKS_RESET = 8'd50;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_WRITE   = 3'd3,
        OP_READ    = 3'd4,
        OP_RECOVER = 3'd5
    } op_t;

    // active command, one-hot
    typedef enum logic [5:0] {
        CMD_IDLE    = 6'b000001,
        CMD_START   = 6'b000010,
        CMD_STOP    = 6'b000100,
        CMD_WRITE   = 6'b001000,
        CMD_READ    = 6'b010000,
        CMD_RECOVER = 6'b100000
    } cmd_t;

endpackage

/* hw/rtl/i2cm_ifs.sv */
// request, result and configuration channel interfaces
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_level;

    modport source (output valid, output operation, output tx_byte, output send_ack,
                    output sda_level, input ready);
    modport sink   (input valid, input operation, input tx_byte, input send_ack,
                    input sda_level, output ready);
endinterface

interface i2cm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       acked;
    logic       sda_freed;

    modport source (output valid, output scl_release, output sda_release, output busy_res,
                    output done_res, output rx_byte, output acked, output sda_freed,
                    input ready);
    modport sink   (input valid, input scl_release, input sda_release, input busy_res,
                    input done_res, input rx_byte, input acked, input sda_freed,
                    output ready);
endinterface

interface i2cm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/i2c_master_bit_engine.sv */
// i2c master bit engine: open-drain scl/sda sequencer, one tick per request
// a request is captured in the input register, then goes through the step logic
// into the result register
// throughput: one request per cycle while results are taken; a held result
// stalls the input register, which stalls the request channel
// reset: async active low; idle, both lines released, phase_ticks = 50
`include "assert_macros.svh"

module i2c_master_bit_engine (
    input  logic        clk,
    input  logic        rst_n,
    i2cm_req_if.sink    req,
    i2cm_rsp_if.source  rsp,
    i2cm_cfg_if.sink    cfg
);
    import i2cm_pkg::*;

    // configuration
    logic [TIMER_W-1:0]  phase_ticks_reg;

    // input register
    logic                in_vld_reg;
    logic [OP_W-1:0]     in_op_reg;
    logic [7:0]          in_tx_reg;
    logic                in_ack_reg;
    logic                in_sda_reg;

    // sequencer state
    cmd_t                cmd_reg, cmd_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [7:0]          shift_reg, shift_next;
    logic                ack_flag_reg, ack_flag_next;
    logic                rec_flag_reg, rec_flag_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic [7:0]          rx_hold_reg, rx_hold_next;
    logic                ack_send_reg, ack_send_next;

    // result register
    logic                out_vld_reg;
    logic                out_busy_reg;
    logic                out_done_reg;

    logic                advance;
    logic                run;
    logic                fin;
    cmd_t                start_cmd;
    logic [TIMER_W-1:0]  load_ticks;

    // a request moves through the step logic when the result slot frees up
    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;
    assign cfg.ready = 1'b1;

    // zero phase length behaves as one tick
    assign load_ticks = (phase_ticks_reg == '0) ? TIMER_W'(1) : phase_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            phase_ticks_reg <= cfg.data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_op_reg  <= req.operation;
            in_tx_reg  <= req.tx_byte;
            in_ack_reg <= req.send_ack;
            in_sda_reg <= req.sda_level;
        end
    end

    // decode of a new operation, codes past recover are ignored
    always_comb
    begin
        unique case (in_op_reg)
            OP_START:   start_cmd = CMD_START;
            OP_STOP:    start_cmd = CMD_STOP;
            OP_WRITE:   start_cmd = CMD_WRITE;
            OP_READ:    start_cmd = CMD_READ;
            OP_RECOVER: start_cmd = CMD_RECOVER;
            OP_NONE:    start_cmd = CMD_IDLE;
            default:    start_cmd = CMD_IDLE;
        endcase
    end

    // one tick of the sequencer
    always_comb
    begin
        cmd_next      = cmd_reg;
        step_next     = step_reg;
        bit_cnt_next  = bit_cnt_reg;
        timer_next    = timer_reg;
        shift_next    = shift_reg;
        ack_flag_next = ack_flag_reg;
        rec_flag_next = rec_flag_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        rx_hold_next  = rx_hold_reg;
        ack_send_next = ack_send_reg;
        run           = 1'b0;
        fin           = 1'b0;

        if (advance)
        begin
            if (cmd_reg == CMD_IDLE)
            begin
                // commands are taken only while idle
                if (start_cmd != CMD_IDLE)
                begin
                    cmd_next     = start_cmd;
                    step_next    = '0;
                    bit_cnt_next = '0;
                    if (start_cmd == CMD_WRITE)
                    begin
                        shift_next = in_tx_reg;
                    end
                    if (start_cmd == CMD_READ)
                    begin
                        shift_next    = '0;
                        ack_send_next = in_ack_reg;
                    end
                    run = 1'b1;
                end
            end
            else if (timer_reg > TIMER_W'(1))
            begin
                timer_next = timer_reg - TIMER_W'(1);
            end
            else
            begin
                run = 1'b1;
            end
        end

        if (run)
        begin
            unique case (cmd_next)
                CMD_START:
                begin
                    case (step_next)
                        3'd0:    sda_next = 1'b1;
                        3'd1:    scl_next = 1'b1;
                        3'd2:    sda_next = 1'b0;
                        3'd3:    scl_next = 1'b0;
                        default: fin = 1'b1;
                    endcase
                    step_next = step_next + STEP_W'(1);
                end
                CMD_STOP:
                begin
                    case (step_next)
                        3'd0:    sda_next = 1'b0;
                        3'd1:    scl_next = 1'b1;
                        3'd2:    sda_next = 1'b1;
                        default: fin = 1'b1;
                    endcase
                    step_next = step_next + STEP_W'(1);
                end
                CMD_WRITE:
                begin
                    case (step_next)
                        3'd0:
                        begin
                            scl_next  = 1'b0;
                            step_next = 3'd1;
                        end
                        3'd1:
                        begin
                            sda_next  = shift_next[7];
                            step_next = 3'd2;
                        end
                        3'd2:
                        begin
                            scl_next     = 1'b1;
                            shift_next   = {shift_next[6:0], 1'b0};
                            bit_cnt_next = bit_cnt_next + BITCNT_W'(1);
                            step_next    = (bit_cnt_next < BYTE_BITS) ? 3'd0 : 3'd3;
                        end
                        3'd3:
                        begin
                            scl_next  = 1'b0;
                            step_next = 3'd4;
                        end
                        3'd4:
                        begin
                            sda_next  = 1'b1;
                            step_next = 3'd5;
                        end
                        3'd5:
                        begin
                            scl_next  = 1'b1;
                            step_next = 3'd6;
                        end
                        3'd6:
                        begin
                            // low sda on the acknowledge clock pulse is an ack
                            ack_flag_next = !in_sda_reg;
                            scl_next      = 1'b0;
                            step_next     = 3'd7;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                CMD_READ:
                begin
                    case (step_next)
                        3'd0:
                        begin
                            sda_next  = 1'b1;
                            scl_next  = 1'b0;
                            step_next = 3'd1;
                        end
                        3'd1:
                        begin
                            scl_next  = 1'b1;
                            step_next = 3'd2;
                        end
                        3'd2:
                        begin
                            shift_next   = {shift_next[6:0], in_sda_reg};
                            bit_cnt_next = bit_cnt_next + BITCNT_W'(1);
                            scl_next     = 1'b0;
                            step_next    = (bit_cnt_next < BYTE_BITS) ? 3'd1 : 3'd3;
                        end
                        3'd3:
                        begin
                            sda_next  = !ack_send_next;
                            step_next = 3'd4;
                        end
                        3'd4:
                        begin
                            scl_next  = 1'b1;
                            step_next = 3'd5;
                        end
                        3'd5:
                        begin
                            scl_next  = 1'b0;
                            step_next = 3'd6;
                        end
                        3'd6:
                        begin
                            // release sda and finish with no trailing phase
                            sda_next     = 1'b1;
                            rx_hold_next = shift_next;
                            fin          = 1'b1;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                CMD_RECOVER:
                begin
                    case (step_next)
                        3'd0:
                        begin
                            sda_next      = 1'b1;
                            scl_next      = 1'b0;
                            rec_flag_next = 1'b0;
                            step_next     = 3'd1;
                        end
                        3'd1:
                        begin
                            scl_next     = 1'b1;
                            bit_cnt_next = bit_cnt_next + BITCNT_W'(1);
                            step_next    = 3'd2;
                        end
                        3'd2:
                        begin
                            if (in_sda_reg)
                            begin
                                // bus freed, finish with a stop
                                rec_flag_next = 1'b1;
                                sda_next      = 1'b0;
                                step_next     = 3'd3;
                            end
                            else if (bit_cnt_next < RECOVER_PULSES)
                            begin
                                scl_next  = 1'b0;
                                step_next = 3'd1;
                            end
                            else
                            begin
                                // out of pulses, stop anyway
                                sda_next  = 1'b0;
                                step_next = 3'd3;
                            end
                        end
                        3'd3:
                        begin
                            scl_next  = 1'b1;
                            step_next = 3'd4;
                        end
                        3'd4:
                        begin
                            sda_next  = 1'b1;
                            step_next = 3'd5;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                default: fin = 1'b1;
            endcase

            if (fin)
            begin
                cmd_next   = CMD_IDLE;
                step_next  = '0;
                timer_next = '0;
            end
            else
            begin
                timer_next = load_ticks;
            end
        end
    end

    // sequencer state, updated only when a request passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= CMD_IDLE;
            step_reg     <= '0;
            bit_cnt_reg  <= '0;
            timer_reg    <= '0;
            shift_reg    <= '0;
            ack_flag_reg <= 1'b0;
            rec_flag_reg <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            rx_hold_reg  <= '0;
            ack_send_reg <= 1'b0;
        end
        else if (advance)
        begin
            cmd_reg      <= cmd_next;
            step_reg     <= step_next;
            bit_cnt_reg  <= bit_cnt_next;
            timer_reg    <= timer_next;
            shift_reg    <= shift_next;
            ack_flag_reg <= ack_flag_next;
            rec_flag_reg <= rec_flag_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            rx_hold_reg  <= rx_hold_next;
            ack_send_reg <= ack_send_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_busy_reg <= (cmd_next != CMD_IDLE);
            out_done_reg <= fin;
        end
    end

    // line and status fields come straight from the state just written
    assign rsp.valid       = out_vld_reg;
    assign rsp.scl_release = scl_reg;
    assign rsp.sda_release = sda_reg;
    assign rsp.busy_res    = out_busy_reg;
    assign rsp.done_res    = out_done_reg;
    assign rsp.rx_byte     = rx_hold_reg;
    assign rsp.acked       = ack_flag_reg;
    assign rsp.sda_freed   = rec_flag_reg;

    // a shown completion always leaves the sequencer idle
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, out_vld_reg && out_done_reg, cmd_reg == CMD_IDLE)
    // a running sequence always has a live phase timer
    `ASSERT_IMPLIES(a_timer_live, clk, rst_n, cmd_reg != CMD_IDLE, timer_reg != '0)
    // a stalled input register keeps its request
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_reg && !advance,
                 in_vld_reg && $stable(in_op_reg) && $stable(in_sda_reg))
    // busy flag in the result matches the sequencer state
    `ASSERT_IMPLIES(a_busy_match, clk, rst_n, out_vld_reg,
                    out_busy_reg == (cmd_reg != CMD_IDLE))

endmodule

/* tb/i2c_master_bit_engine_chk.sv */
`timescale 1ns / 1ps
// checker for the i2c master bit engine: predicts every result and compares it
module i2c_master_bit_engine_chk (
    input  logic clk,
    input  logic rst_n,
    i2cm_req_if  req,
    i2cm_rsp_if  rsp,
    i2cm_cfg_if  cfg,
    output int   mismatches,
    output int   pending,
    output logic engine_busy,
    output int   checked,
    output int   cmds_started,
    output int   long_recovers
);
    import i2cm_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       acked;
        logic       freed;
    } bus_snapshot_t;

    // own copy of the engine state
    logic [7:0]    phase_len;
    logic [4:0]    step;
    logic [3:0]    bit_cnt;
    logic [7:0]    timer;
    logic [7:0]    shift_reg;
    op_t           cmd;
    logic          ack_seen;
    logic          sda_seen_free;
    logic          scl_q;
    logic          sda_q;
    logic [7:0]    rx_hold;
    logic          ack_out;

    bus_snapshot_t snapshot_q[$];
    bus_snapshot_t got_snap;
    bus_snapshot_t want_snap;
    int            fail_cnt;
    int            result_cnt;
    int            start_cnt;
    int            stuck_cnt;

    // applies the action of the current step, returns 1 when the sequence ends
    function automatic logic seq_step(logic sda_in);
        logic fin;
        fin = 1'b0;
        case (cmd)
            OP_START: begin
                case (step)
                    5'd0:    sda_q = 1'b1;
                    5'd1:    scl_q = 1'b1;
                    5'd2:    sda_q = 1'b0;
                    5'd3:    scl_q = 1'b0;
                    default: fin = 1'b1;
                endcase
                if (!fin)
                    step = step + 5'd1;
            end
            OP_STOP: begin
                case (step)
                    5'd0:    sda_q = 1'b0;
                    5'd1:    scl_q = 1'b1;
                    5'd2:    sda_q = 1'b1;
                    default: fin = 1'b1;
                endcase
                if (!fin)
                    step = step + 5'd1;
            end
            OP_WRITE: begin
                case (step)
                    5'd0: begin scl_q = 1'b0; step = 5'd1; end
                    5'd1: begin sda_q = shift_reg[7]; step = 5'd2; end
                    5'd2:
                    begin
                        scl_q     = 1'b1;
                        shift_reg = {shift_reg[6:0], 1'b0};
                        bit_cnt   = bit_cnt + 4'd1;
                        step      = (bit_cnt < BYTE_BITS) ? 5'd0 : 5'd3;
                    end
                    5'd3: begin scl_q = 1'b0; step = 5'd4; end
                    5'd4: begin sda_q = 1'b1; step = 5'd5; end
                    5'd5: begin scl_q = 1'b1; step = 5'd6; end
                    5'd6: begin ack_seen = ~sda_in; scl_q = 1'b0; step = 5'd7; end
                    default: fin = 1'b1;
                endcase
            end
            OP_READ: begin
                case (step)
                    5'd0: begin sda_q = 1'b1; scl_q = 1'b0; step = 5'd1; end
                    5'd1: begin scl_q = 1'b1; step = 5'd2; end
                    5'd2:
                    begin
                        shift_reg = {shift_reg[6:0], sda_in};
                        bit_cnt   = bit_cnt + 4'd1;
                        scl_q     = 1'b0;
                        step      = (bit_cnt < BYTE_BITS) ? 5'd1 : 5'd3;
                    end
                    5'd3: begin sda_q = ~ack_out; step = 5'd4; end
                    5'd4: begin scl_q = 1'b1; step = 5'd5; end
                    5'd5: begin scl_q = 1'b0; step = 5'd6; end
                    5'd6: begin sda_q = 1'b1; rx_hold = shift_reg; fin = 1'b1; end
                    default: fin = 1'b1;
                endcase
            end
            OP_RECOVER: begin
                case (step)
                    5'd0:
                    begin
                        sda_q         = 1'b1;
                        scl_q         = 1'b0;
                        sda_seen_free = 1'b0;
                        step          = 5'd1;
                    end
                    5'd1: begin scl_q = 1'b1; bit_cnt = bit_cnt + 4'd1; step = 5'd2; end
                    5'd2:
                    begin
                        if (sda_in)
                        begin
                            sda_seen_free = 1'b1;
                            sda_q         = 1'b0;
                            step          = 5'd3;
                        end
                        else if (bit_cnt < RECOVER_PULSES)
                        begin
                            scl_q = 1'b0;
                            step  = 5'd1;
                        end
                        else
                        begin
                            // pulses used up with sda still held low
                            sda_q     = 1'b0;
                            step      = 5'd3;
                            stuck_cnt = stuck_cnt + 1;
                        end
                    end
                    5'd3: begin scl_q = 1'b1; step = 5'd4; end
                    5'd4: begin sda_q = 1'b1; step = 5'd5; end
                    default: fin = 1'b1;
                endcase
            end
            default: fin = 1'b1;
        endcase
        if (fin)
        begin
            cmd   = OP_NONE;
            step  = 5'd0;
            timer = 8'd0;
        end
        else
            timer = (phase_len != 8'd0) ? phase_len : 8'd1;
        return fin;
    endfunction

    // one tick of the engine: expected pin and status snapshot
    function automatic bus_snapshot_t engine_tick(logic [2:0] op, logic [7:0] tx,
                                                  logic ack_req, logic sda_in);
        bus_snapshot_t s;
        logic          done;
        done = 1'b0;
        if (cmd == OP_NONE)
        begin
            if (op >= OP_START && op <= OP_RECOVER)
            begin
                cmd       = op_t'(op);
                step      = 5'd0;
                bit_cnt   = 4'd0;
                start_cnt = start_cnt + 1;
                if (cmd == OP_WRITE)
                    shift_reg = tx;
                if (cmd == OP_READ)
                begin
                    shift_reg = 8'd0;
                    ack_out   = ack_req;
                end
                done = seq_step(sda_in);
            end
        end
        else if (timer > 8'd1)
            timer = timer - 8'd1;
        else
            done = seq_step(sda_in);
        s.scl   = scl_q;
        s.sda   = sda_q;
        s.busy  = (cmd != OP_NONE);
        s.done  = done;
        s.rx    = rx_hold;
        s.acked = ack_seen;
        s.freed = sda_seen_free;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_len     = PHASE_TICKS_RESET;
            step          = 5'd0;
            bit_cnt       = 4'd0;
            timer         = 8'd0;
            shift_reg     = 8'd0;
            cmd           = OP_NONE;
            ack_seen      = 1'b0;
            sda_seen_free = 1'b0;
            scl_q         = 1'b1;
            sda_q         = 1'b1;
            rx_hold       = 8'd0;
            ack_out       = 1'b0;
            fail_cnt      = 0;
            result_cnt    = 0;
            start_cnt     = 0;
            stuck_cnt     = 0;
            snapshot_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                phase_len = cfg.data;
            // compare before predicting: a request never yields its result on the same edge
            if (rsp.valid && rsp.ready)
            begin
                got_snap.scl   = rsp.scl_release;
                got_snap.sda   = rsp.sda_release;
                got_snap.busy  = rsp.busy_res;
                got_snap.done  = rsp.done_res;
                got_snap.rx    = rsp.rx_byte;
                got_snap.acked = rsp.acked;
                got_snap.freed = rsp.sda_freed;
                result_cnt = result_cnt + 1;
                if (snapshot_q.size() == 0)
                begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= 10)
                        $display("result %0d arrived with no request outstanding", result_cnt);
                end
                else
                begin
                    want_snap = snapshot_q.pop_front();
                    if (got_snap.scl !== want_snap.scl || got_snap.sda !== want_snap.sda ||
                        got_snap.busy !== want_snap.busy || got_snap.done !== want_snap.done ||
                        got_snap.rx !== want_snap.rx || got_snap.acked !== want_snap.acked ||
                        got_snap.freed !== want_snap.freed)
                    begin
                        fail_cnt = fail_cnt + 1;
                        if (fail_cnt <= 10)
                            $display({"result %0d: expected scl %b sda %b busy %b done %b ",
                                      "rx %h acked %b freed %b, got scl %b sda %b busy %b ",
                                      "done %b rx %h acked %b freed %b"},
                                     result_cnt, want_snap.scl, want_snap.sda,
                                     want_snap.busy, want_snap.done, want_snap.rx,
                                     want_snap.acked, want_snap.freed, got_snap.scl,
                                     got_snap.sda, got_snap.busy, got_snap.done,
                                     got_snap.rx, got_snap.acked, got_snap.freed);
                    end
                end
            end
            if (req.valid && req.ready)
                snapshot_q.push_back(engine_tick(req.operation, req.tx_byte,
                                                 req.send_ack, req.sda_level));
        end
        mismatches    <= fail_cnt;
        pending       <= snapshot_q.size();
        engine_busy   <= (cmd != OP_NONE);
        checked       <= result_cnt;
        cmds_started  <= start_cnt;
        long_recovers <= stuck_cnt;
    end

endmodule

/* tb/i2c_master_bit_engine_tb.sv */
`timescale 1ns / 1ps
// testbench top for the i2c master bit engine: stimulus, flow control and verdict
module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    // longest receiver hold-off, well under the watchdog limit
    localparam int HOLD_CYCLES  = 400;
    // cycles without any handshake before the run is declared hung
    localparam int IDLE_LIMIT   = 4000;
    // extra cycles after the last result, a few times the pipeline depth
    localparam int DRAIN_CYCLES = 6;
    // random requests per phase_ticks setting
    localparam int PHASE_ITEMS  = 20;

    // operation codes the engine treats like none
    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    // how the sampled sda level behaves
    typedef enum int {
        SDA_STUCK_LOW,
        SDA_STUCK_HIGH,
        SDA_MOSTLY_LOW,
        SDA_MIXED
    } sda_bias_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    i2cm_req_if req_ch ();
    i2cm_rsp_if rsp_ch ();
    i2cm_cfg_if cfg_ch ();

    int        mismatches;
    int        pending;
    logic      engine_busy;
    int        checked;
    int        cmds_started;
    int        long_recovers;

    int        burst_left;
    sda_bias_t sda_bias;
    bit        bias_roams;
    logic      hold_start;
    int        idle_cycles;
    int        cfg_writes;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    i2c_master_bit_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    i2c_master_bit_engine_chk chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .pending       (pending),
        .engine_busy   (engine_busy),
        .checked       (checked),
        .cmds_started  (cmds_started),
        .long_recovers (long_recovers)
    );

    // sda sample for the next tick, shaped by the current bias
    function automatic logic pick_sda();
        case (sda_bias)
            SDA_STUCK_LOW:  return 1'b0;
            SDA_STUCK_HIGH: return 1'b1;
            SDA_MOSTLY_LOW: return ($urandom_range(0, 9) == 0);
            default:        return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // random operation: mostly real commands, some none and unused codes
    function automatic logic [2:0] random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return OP_NONE;
        else if (r < 20)
            return ($urandom_range(0, 1) != 0) ? OP_RSVD_A : OP_RSVD_B;
        else
            return 3'($urandom_range(OP_START, OP_RECOVER));
    endfunction

    // offer one request (one tick) and wait until it is taken
    // the sender works in bursts; between bursts valid may drop for a while
    task automatic send_item(input logic [2:0] op, input logic [7:0] tx, input logic ack);
        int gap;
        if (burst_left == 0)
        begin
            // a zero gap joins two bursts into one unbroken stretch
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
            if (bias_roams)
                sda_bias = sda_bias_t'($urandom_range(SDA_STUCK_LOW, SDA_MIXED));
        end
        burst_left = burst_left - 1;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.tx_byte   <= tx;
        req_ch.send_ack  <= ack;
        req_ch.sda_level <= pick_sda();
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // feed none ticks until the predicted engine has gone idle
    // engine_busy lags one request, so at least one tick always goes out
    task automatic idle_out();
        do
        begin
            send_item(OP_NONE, 8'($urandom), 1'($urandom));
        end
        while (engine_busy);
    endtask

    // one command from start to completion
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input sda_bias_t bias);
        sda_bias = bias;
        send_item(op, tx, ack);
        idle_out();
    endtask

    // engine idle, request channel quiet, every result back, pipeline empty
    task automatic settle();
        idle_out();
        req_ch.valid <= 1'b0;
        // pending is a registered copy as well
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // new phase_ticks, written only while the engine and pipeline are idle
    task automatic write_phase(input logic [7:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes = cfg_writes + 1;
    endtask

    // receiver: rotating pattern of always ready, a fixed duty cycle and random stalls,
    // plus one long hold-off on request from the stimulus
    initial
    begin
        int cyc;
        bit hold_served;
        cyc         = 0;
        hold_served = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc = cyc + 1;
            if (hold_start && !hold_served)
            begin
                hold_served = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case ((cyc / 64) % 3)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ((cyc % 4) != 3);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog: ends the run when no channel moves anything for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("no handshake for %0d cycles, run stopped", IDLE_LIMIT);
        $display("i2c_master_bit_engine verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [7:0] phase_plan [6];
        phase_plan = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd1, 8'd4};

        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_NONE;
        req_ch.tx_byte   <= 8'd0;
        req_ch.send_ack  <= 1'b0;
        req_ch.sda_level <= 1'b1;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= 8'd0;
        hold_start       <= 1'b0;
        burst_left = 0;
        bias_roams = 1'b0;
        sda_bias   = SDA_MIXED;
        cfg_writes = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stop at the reset phase length
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom), SDA_MIXED);

        // fastest bus for the directed byte commands
        write_phase(8'd1);
        // write all ones with the slave acking, all zeros with a nack
        run_cmd(OP_WRITE, 8'hFF, 1'b0, SDA_STUCK_LOW);
        run_cmd(OP_WRITE, 8'h00, 1'b1, SDA_STUCK_HIGH);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_MIXED);
        // read 0xff and send ack, read 0x00 and send nack
        run_cmd(OP_READ, 8'h00, 1'b1, SDA_STUCK_HIGH);
        run_cmd(OP_READ, 8'hFF, 1'b0, SDA_STUCK_LOW);
        run_cmd(OP_READ, 8'($urandom), 1'b1, SDA_MIXED);
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom), SDA_MIXED);
        // recover: sda stuck low uses every pulse, sda high stops at once
        run_cmd(OP_RECOVER, 8'($urandom), 1'($urandom), SDA_STUCK_LOW);
        run_cmd(OP_RECOVER, 8'($urandom), 1'($urandom), SDA_STUCK_HIGH);
        run_cmd(OP_RECOVER, 8'($urandom), 1'($urandom), SDA_MOSTLY_LOW);
        // unused operation codes behave like none
        send_item(OP_RSVD_A, 8'($urandom), 1'($urandom));
        send_item(OP_RSVD_B, 8'($urandom), 1'($urandom));
        // commands offered while a start runs must be dropped
        sda_bias = SDA_MIXED;
        send_item(OP_START, 8'($urandom), 1'($urandom));
        repeat (3) send_item(OP_WRITE, 8'($urandom), 1'($urandom));
        send_item(OP_RECOVER, 8'($urandom), 1'($urandom));
        idle_out();

        // zero phase length acts as one tick
        write_phase(8'd0);
        run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), SDA_MIXED);

        // random part: back-to-back command streams at short phase lengths,
        // with the sda bias changing per burst
        bias_roams = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            write_phase((i == 5) ? 8'($urandom_range(1, 6)) : phase_plan[i]);
            // one long receiver hold-off while requests keep coming
            if (i == 2)
                hold_start <= 1'b1;
            repeat (PHASE_ITEMS) send_item(random_op(), 8'($urandom), 1'($urandom));
        end

        // everything back, then a few quiet cycles to catch stray results
        settle();

        $display("checked %0d results, %0d commands started, %0d recovers out of pulses",
                 checked, cmds_started, long_recovers);
        $display("%0d phase_ticks writes, including 0 and 1", cfg_writes);
        if (mismatches == 0 && pending == 0)
            $display("i2c_master_bit_engine verification clean");
        else
            $display("i2c_master_bit_engine verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_ifs.sv
hw/rtl/i2c_master_bit_engine.sv
tb/i2c_master_bit_engine_chk.sv
tb/i2c_master_bit_engine_tb.sv
